/* design/ete_pkg.sv */
// ----------------------------------------------------------------------------
// ete_pkg
// token kind codes and sequencer state encoding for the expression evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package ete_pkg;

    localparam int KIND_BITS = 3;

    localparam logic [KIND_BITS-1:0] KIND_NUM = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_ADD = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_SUB = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_MUL = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_DIV = 3'd4;

    localparam int OUT_BITS = 32;
    localparam int LIT_BITS = 32;

    typedef enum logic [9:0] {
        S_LOAD   = 10'b00_0000_0001,
        S_KIND   = 10'b00_0000_0010,
        S_CHK    = 10'b00_0000_0100,
        S_LEFT   = 10'b00_0000_1000,
        S_RIGHT  = 10'b00_0001_0000,
        S_ITER   = 10'b00_0010_0000,
        S_WR     = 10'b00_0100_0000,
        S_NEXT   = 10'b00_1000_0000,
        S_ROOT   = 10'b01_0000_0000,
        S_ROOT_W = 10'b10_0000_0000
    } state_t;

endpackage

`default_nettype wire

/* design/ete_ram.sv */
// ----------------------------------------------------------------------------
// ete_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ete_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/expression_tree_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// expression_tree_evaluator_unit
// level-order expression tree loader and bottom-up evaluator
//
// tokens arrive on the token channel (valid/ready), one beat per tree node,
// node i having its children at 2i+1 and 2i+2. token_ready stays high while
// loading. the beat with final_token set starts a bottom-up pass from the
// highest node down to the root, after which one result beat carries
// root_value, zero_divide and malformed. token_ready is low for the pass.
// per node, all through the single node ram read port, the pass reads the
//   kind; a number or an operator lacking a child is then done, else both
//   children are read and add/subtract or a divide by zero is written at
//   once, while multiply/divide first run bit-serial (shift-add multiply,
//   restoring divide). the root is then read back and registered.
// the result sits in an output register; loading of the next tree may start
// while it waits. a stalled receiver holds the pass after the root read
// until the previous result is taken. reset empties the tree and the output;
// the node ram needs no clearing since only nodes of the current tree are read.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_tree_evaluator_unit
    import ete_pkg::*;
#(
    parameter int MAX_NODES  = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 token_valid,
    output logic                      token_ready,
    input  wire logic [KIND_BITS-1:0] kind,
    input  wire logic signed [31:0]   literal,
    input  wire logic                 final_token,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic signed [31:0]        root_value,
    output logic                      zero_divide,
    output logic                      malformed
);

    localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int IW   = AW + 2;
    localparam int VB   = VALUE_BITS;
    localparam int DW   = KIND_BITS + VB;
    localparam int CNTW = $clog2(VALUE_BITS + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 bad_reg, bad_next;
    logic                 zdiv_reg, zdiv_next;
    logic [KIND_BITS-1:0] op_reg, op_next;
    logic [VB-1:0]        x_reg, x_next;
    logic [VB-1:0]        y_reg, y_next;
    logic [VB-1:0]        acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          root_reg, root_next;
    logic                 ozd_reg, ozd_next;
    logic                 obad_reg, obad_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [DW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [DW-1:0]        ram_rdata;

    logic [KIND_BITS-1:0] rd_kind;
    logic [VB-1:0]        rd_val;
    logic [VB-1:0]        lit_ext;
    logic [31:0]          rd_root;
    logic [IW-1:0]        li_wide;
    logic [IW-1:0]        ri_wide;
    logic                 full;
    logic                 tok_beat;
    logic [VB:0]          div_t;
    logic [VB:0]          div_s;
    logic [VB-1:0]        mag_a;
    logic [VB-1:0]        mag_b;

    assign rd_kind  = ram_rdata[DW-1 -: KIND_BITS];
    assign rd_val   = ram_rdata[VB-1:0];
    assign full     = (count_reg >= CW'(MAX_NODES));
    assign tok_beat = token_valid && token_ready;
    assign li_wide  = {1'b0, idx_reg, 1'b1};
    assign ri_wide  = {1'b0, idx_reg, 1'b0} + IW'(2);
    assign mag_a    = x_reg[VB-1] ? (VB'(0) - x_reg) : x_reg;
    assign mag_b    = rd_val[VB-1] ? (VB'(0) - rd_val) : rd_val;
    assign div_t    = {acc_reg, y_reg[VB-1]};
    assign div_s    = div_t - {1'b0, x_reg};

    always_comb
    begin
        for (int j = 0; j < VB; j++)
        begin
            lit_ext[j] = (j < LIT_BITS) ? literal[(j < LIT_BITS) ? j : LIT_BITS-1]
                                        : literal[LIT_BITS-1];
        end
        for (int j = 0; j < OUT_BITS; j++)
        begin
            rd_root[j] = (j < VB) ? rd_val[(j < VB) ? j : 0] : 1'b0;
        end
    end

    ete_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        bad_next       = bad_reg;
        zdiv_next      = zdiv_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        root_next      = root_reg;
        ozd_next       = ozd_reg;
        obad_next      = obad_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = {op_reg, acc_reg};
        ram_re         = 1'b0;
        ram_raddr      = idx_reg;
        token_ready    = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                token_ready = 1'b1;
                if (tok_beat)
                begin
                    ram_we    = !full;
                    ram_waddr = count_reg[AW-1:0];
                    ram_wdata = {kind, lit_ext};
                    if (final_token)
                    begin
                        n_next     = full ? count_reg : count_reg + CW'(1);
                        idx_next   = full ? AW'(count_reg - CW'(1)) : count_reg[AW-1:0];
                        bad_next   = ovf_reg || full;
                        zdiv_next  = 1'b0;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_KIND;
                    end
                    else if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            S_KIND:
            begin
                ram_re     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                op_next = rd_kind;
                if (!(rd_kind inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV}))
                begin
                    state_next = S_NEXT;
                end
                else if (ri_wide >= IW'(n_reg))
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {rd_kind, VB'(0)};
                    bad_next   = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = li_wide[AW-1:0];
                    state_next = S_LEFT;
                end
            end
            S_LEFT:
            begin
                x_next     = rd_val;
                ram_re     = 1'b1;
                ram_raddr  = ri_wide[AW-1:0];
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                cnt_next   = CNTW'(VALUE_BITS);
                acc_next   = '0;
                state_next = S_ITER;
                case (op_reg)
                    KIND_ADD:
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = {op_reg, x_reg + rd_val};
                        state_next = S_NEXT;
                    end
                    KIND_SUB:
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = {op_reg, x_reg - rd_val};
                        state_next = S_NEXT;
                    end
                    KIND_MUL:
                    begin
                        y_next = rd_val;
                    end
                    default:
                    begin
                        if (rd_val == VB'(0))
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = {op_reg, VB'(0)};
                            zdiv_next  = 1'b1;
                            state_next = S_NEXT;
                        end
                        else
                        begin
                            x_next   = mag_b;
                            y_next   = mag_a;
                            neg_next = x_reg[VB-1] ^ rd_val[VB-1];
                        end
                    end
                endcase
            end
            S_ITER:
            begin
                cnt_next = cnt_reg - CNTW'(1);
                if (op_reg == KIND_MUL)
                begin
                    acc_next = y_reg[0] ? acc_reg + x_reg : acc_reg;
                    x_next   = x_reg << 1;
                    y_next   = y_reg >> 1;
                end
                else if (!div_s[VB])
                begin
                    acc_next = div_s[VB-1:0];
                    y_next   = {y_reg[VB-2:0], 1'b1};
                end
                else
                begin
                    acc_next = div_t[VB-1:0];
                    y_next   = {y_reg[VB-2:0], 1'b0};
                end
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                ram_we = 1'b1;
                if (op_reg == KIND_MUL)
                begin
                    ram_wdata = {op_reg, acc_reg};
                end
                else
                begin
                    ram_wdata = {op_reg, neg_reg ? (VB'(0) - y_reg) : y_reg};
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (idx_reg == AW'(0))
                begin
                    state_next = S_ROOT;
                end
                else
                begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_KIND;
                end
            end
            S_ROOT:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(0);
                state_next = S_ROOT_W;
            end
            S_ROOT_W:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    root_next      = rd_root;
                    ozd_next       = zdiv_reg;
                    obad_next      = bad_reg;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        bad_reg  <= bad_next;
        zdiv_reg <= zdiv_next;
        op_reg   <= op_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        root_reg <= root_next;
        ozd_reg  <= ozd_next;
        obad_reg <= obad_next;
    end

    assign result_valid = out_valid_reg;
    assign root_value   = root_reg;
    assign zero_divide  = ozd_reg;
    assign malformed    = obad_reg;

    // a node is never read back in the cycle it is written
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("node ram read and write collide");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_NODES))
        else $error("token count beyond tree capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tok_beat && final_token) |=> (!token_ready && count_reg == '0))
        else $error("final beat did not start evaluation");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> (CW'(idx_reg) < n_reg))
        else $error("node index outside current tree");

endmodule

`default_nettype wire
